### rtl/queue_timeline_sync_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Queue timeline sync tracker assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef QUEUE_TIMELINE_SYNC_TRACKER_TOP_MACROS_SVH
`define QUEUE_TIMELINE_SYNC_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QTST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qtst assertion failed");

// Next-cycle implication, checked outside reset.
`define QTST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qtst assertion failed");

`endif

### rtl/qtst_pkg.sv
// ----------------------------------------------------------------------------
// Queue timeline sync tracker package
// Opcodes, status codes, default sizes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package qtst_pkg;

    localparam int TL_W       = 64;
    localparam int MASK_W     = 32;
    localparam int OP_W       = 3;
    localparam int QUEUE_W    = 2;
    localparam int STATUS_W   = 2;

    localparam int DEF_WAIT_DEPTH  = 8;
    localparam int DEF_QUEUE_COUNT = 4;
    localparam int DEF_STAGE_BITS  = 32;

    localparam logic [QUEUE_W-1:0] SHARED_SLOT = 2'd1;
    localparam logic [QUEUE_W-1:0] ASYNC_QUEUE = 2'd3;

    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_WAIT   = 3'd1;
    localparam logic [OP_W-1:0] OP_COMMIT = 3'd2;
    localparam logic [OP_W-1:0] OP_RESET  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST   = 3'd5;
    localparam logic [OP_W-1:0] OP_DEAD   = 3'd6;

    localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_ALLOC = 2'd2;

    // Control of the wait graph unit.
    typedef struct packed {
        logic clear;
        logic set_edge;
        logic close_step;
    } cyc_ctl_t;

    // Async compute folds onto the compute slot when sharing is enabled.
    function automatic logic [QUEUE_W-1:0] map_queue(input logic [QUEUE_W-1:0] q,
                                                     input logic shares);
        logic [QUEUE_W-1:0] m;
        m = q;
        if (q == ASYNC_QUEUE && shares)
            m = SHARED_SLOT;
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/queue_timeline_sync_tracker_top.sv
// ----------------------------------------------------------------------------
// Queue timeline sync tracker
// Timeline counters and pending waits per queue slot, with deadlock search.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one command (opcode, queue,
// source_queue, wait_target, stage_mask). Output channel: out_valid/out_stall
// carry result items; last marks the final result of a command. The user
// writes the async_shares_compute register through cfg_wr_en/cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// One command is in flight at a time. A command reads its slot from the
// counter memory as it is transferred, and ST_EXE loads its result into the
// output register once that register is free, for allocate, wait, commit,
// reset, read and the unused opcode. List waits gives one result per entry,
// one wait-memory read each. A deadlock check snapshots every slot, reads
// each pending wait once, then closes the graph one pivot per cycle.
// Reset clears all counters through per-slot valid bits and keeps the
// register at 0. A stalled result holds in the output register; the next
// command is still taken while it waits, and the block then stalls at its
// own result until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "queue_timeline_sync_tracker_top_macros.svh"

module queue_timeline_sync_tracker_top #(
    parameter int WAIT_DEPTH  = qtst_pkg::DEF_WAIT_DEPTH,
    parameter int QUEUE_COUNT = qtst_pkg::DEF_QUEUE_COUNT,
    parameter int STAGE_BITS  = qtst_pkg::DEF_STAGE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic                              cfg_wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [qtst_pkg::OP_W-1:0]         opcode,
    input  wire logic [qtst_pkg::QUEUE_W-1:0]      queue,
    input  wire logic [qtst_pkg::QUEUE_W-1:0]      source_queue,
    input  wire logic [qtst_pkg::TL_W-1:0]         wait_target,
    input  wire logic [qtst_pkg::MASK_W-1:0]       stage_mask,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [qtst_pkg::STATUS_W-1:0]          status,
    output logic [qtst_pkg::TL_W-1:0]              allocated_value,
    output logic [qtst_pkg::TL_W-1:0]              committed_value,
    output logic [qtst_pkg::TL_W-1:0]              upcoming_value,
    output logic                                   entry_valid,
    output logic [qtst_pkg::QUEUE_W-1:0]           entry_source,
    output logic [qtst_pkg::TL_W-1:0]              entry_target,
    output logic [qtst_pkg::MASK_W-1:0]            entry_stage,
    output logic                                   deadlock,
    output logic                                   last
);
    import qtst_pkg::*;

    localparam int SLOT_W  = $clog2(QUEUE_COUNT);
    localparam int CNT_W   = $clog2(WAIT_DEPTH + 1);
    localparam int AW      = $clog2(QUEUE_COUNT * WAIT_DEPTH);
    localparam int STAGE_W = (STAGE_BITS < MASK_W) ? STAGE_BITS : MASK_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_EXE    = 4'd1;
    localparam logic [3:0] ST_LRD    = 4'd2;
    localparam logic [3:0] ST_LDAT   = 4'd3;
    localparam logic [3:0] ST_DSNAP  = 4'd4;
    localparam logic [3:0] ST_DSNAPW = 4'd5;
    localparam logic [3:0] ST_DENT   = 4'd6;
    localparam logic [3:0] ST_DWAIT  = 4'd7;
    localparam logic [3:0] ST_DCLOSE = 4'd8;
    localparam logic [3:0] ST_DOUT   = 4'd9;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_COUNT - 1);

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [QUEUE_W-1:0] m);
        logic [SLOT_W-1:0] r;
        if (int'(m) >= QUEUE_COUNT)
            r = SLOT_W'(int'(m) - QUEUE_COUNT);
        else
            r = SLOT_W'(m);
        return r;
    endfunction

    function automatic logic [AW-1:0] ent_addr(input logic [SLOT_W-1:0] s,
                                               input logic [CNT_W-1:0] k);
        logic [AW-1:0] a;
        a = AW'(s) * AW'(WAIT_DEPTH) + AW'(k);
        return a;
    endfunction

    // Configuration and command registers
    logic              async_reg;
    logic [3:0]        state_reg, state_next;
    logic [OP_W-1:0]   op_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] src_reg;
    logic [TL_W-1:0]   tgt_reg;
    logic [STAGE_W-1:0] stg_reg;

    logic [TL_W-1:0]   cur_next_reg, cur_next_next;
    logic [TL_W-1:0]   cur_comm_reg, cur_comm_next;
    logic [CNT_W-1:0]  cur_cnt_reg, cur_cnt_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [SLOT_W-1:0] i_reg, i_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;

    logic [TL_W-1:0]   comm_snap [QUEUE_COUNT];
    logic [CNT_W-1:0]  cnt_snap  [QUEUE_COUNT];
    logic              snap_we;

    // Memory ports
    logic              cm_clr, cm_rd_en, cm_wr_en;
    logic [SLOT_W-1:0] cm_rd_addr, cm_wr_addr;
    logic [TL_W-1:0]   cm_rd_next, cm_rd_comm, cm_wr_next, cm_wr_comm;
    logic [CNT_W-1:0]  cm_rd_cnt, cm_wr_cnt;

    logic              wm_rd_en, wm_wr_en;
    logic [AW-1:0]     wm_rd_addr, wm_wr_addr;
    logic [SLOT_W-1:0] wm_rd_src;
    logic [TL_W-1:0]   wm_rd_tgt;
    logic [STAGE_W-1:0] wm_rd_stg;

    cyc_ctl_t          cyc_ctl;
    logic              cyc_deadlock;

    // Output register
    logic              out_valid_reg;
    logic              load_out;
    logic              out_free;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [TL_W-1:0]   alloc_reg, alloc_next;
    logic [TL_W-1:0]   comm_reg, comm_next;
    logic [TL_W-1:0]   upc_reg, upc_next;
    logic              ev_reg, ev_next;
    logic [QUEUE_W-1:0] esrc_reg, esrc_next;
    logic [TL_W-1:0]   etgt_reg, etgt_next;
    logic [MASK_W-1:0] estg_reg, estg_next;
    logic              dl_reg, dl_next;
    logic              last_reg, last_next;

    logic              in_xfer;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    qtst_ctr_mem #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .WAIT_DEPTH  (WAIT_DEPTH)
    ) u_ctr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (cm_clr),
        .rd_en   (cm_rd_en),
        .rd_addr (cm_rd_addr),
        .rd_next (cm_rd_next),
        .rd_comm (cm_rd_comm),
        .rd_cnt  (cm_rd_cnt),
        .wr_en   (cm_wr_en),
        .wr_addr (cm_wr_addr),
        .wr_next (cm_wr_next),
        .wr_comm (cm_wr_comm),
        .wr_cnt  (cm_wr_cnt)
    );

    qtst_wait_mem #(
        .QUEUE_COUNT (QUEUE_COUNT),
        .WAIT_DEPTH  (WAIT_DEPTH),
        .STAGE_W     (STAGE_W)
    ) u_wait_mem (
        .clk     (clk),
        .rd_en   (wm_rd_en),
        .rd_addr (wm_rd_addr),
        .rd_src  (wm_rd_src),
        .rd_tgt  (wm_rd_tgt),
        .rd_stg  (wm_rd_stg),
        .wr_en   (wm_wr_en),
        .wr_addr (wm_wr_addr),
        .wr_src  (src_reg),
        .wr_tgt  (tgt_reg),
        .wr_stg  (stg_reg)
    );

    qtst_cycle #(
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_cycle (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cyc_ctl),
        .from_slot (pend_slot_reg),
        .to_slot   (wm_rd_src),
        .step_slot (i_reg),
        .deadlock  (cyc_deadlock)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next_next  = cur_next_reg;
        cur_comm_next  = cur_comm_reg;
        cur_cnt_next   = cur_cnt_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        pend_next      = 1'b0;
        pend_slot_next = pend_slot_reg;
        snap_we        = 1'b0;

        cm_clr     = 1'b0;
        cm_rd_en   = 1'b0;
        cm_rd_addr = wrap_slot(map_queue(queue, async_reg));
        cm_wr_en   = 1'b0;
        cm_wr_addr = slot_reg;
        cm_wr_next = cm_rd_next;
        cm_wr_comm = cm_rd_comm;
        cm_wr_cnt  = cm_rd_cnt;
        wm_rd_en   = 1'b0;
        wm_rd_addr = ent_addr(slot_reg, k_reg);
        wm_wr_en   = 1'b0;
        wm_wr_addr = ent_addr(slot_reg, cm_rd_cnt);
        cyc_ctl    = '0;

        load_out    = 1'b0;
        status_next = STS_OK;
        alloc_next  = cm_rd_next - TL_W'(1);
        comm_next   = cm_rd_comm;
        upc_next    = cm_rd_next;
        ev_next     = 1'b0;
        esrc_next   = '0;
        etgt_next   = '0;
        estg_next   = '0;
        dl_next     = 1'b0;
        last_next   = 1'b1;

        // Unmet wait seen by the deadlock sweep in the cycle after its read.
        if (pend_reg && (comm_snap[wm_rd_src] < wm_rd_tgt))
            cyc_ctl.set_edge = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                cm_rd_en = in_xfer;
                if (in_xfer)
                    state_next = ST_EXE;
            end
            ST_EXE:
            begin
                cur_next_next = cm_rd_next;
                cur_comm_next = cm_rd_comm;
                cur_cnt_next  = cm_rd_cnt;
                if (op_reg == OP_LIST)
                begin
                    k_next = '0;
                    if (cm_rd_cnt != '0)
                        state_next = ST_LRD;
                    else if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (op_reg == OP_DEAD)
                begin
                    cyc_ctl.clear = 1'b1;
                    i_next        = '0;
                    state_next    = ST_DSNAP;
                end
                else if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    unique case (op_reg)
                        OP_ALLOC:
                        begin
                            cm_wr_en   = 1'b1;
                            cm_wr_next = cm_rd_next + TL_W'(1);
                            alloc_next = cm_rd_next;
                            upc_next   = cm_rd_next + TL_W'(1);
                        end
                        OP_WAIT:
                        begin
                            if (cm_rd_cnt < CNT_W'(WAIT_DEPTH))
                            begin
                                wm_wr_en  = 1'b1;
                                cm_wr_en  = 1'b1;
                                cm_wr_cnt = cm_rd_cnt + CNT_W'(1);
                            end
                            else
                                status_next = STS_FULL;
                        end
                        OP_COMMIT:
                        begin
                            cm_wr_en   = 1'b1;
                            cm_wr_comm = cm_rd_next - TL_W'(1);
                            cm_wr_cnt  = '0;
                            comm_next  = cm_rd_next - TL_W'(1);
                        end
                        OP_RESET:
                        begin
                            cm_clr     = 1'b1;
                            alloc_next = '0;
                            comm_next  = '0;
                            upc_next   = TL_W'(1);
                        end
                        OP_READ:
                        begin
                            if (cm_rd_next == TL_W'(1))
                                status_next = STS_NO_ALLOC;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LRD:
            begin
                wm_rd_en   = 1'b1;
                state_next = ST_LDAT;
            end
            ST_LDAT:
            begin
                alloc_next = cur_next_reg - TL_W'(1);
                comm_next  = cur_comm_reg;
                upc_next   = cur_next_reg;
                ev_next    = 1'b1;
                esrc_next  = QUEUE_W'(wm_rd_src);
                etgt_next  = wm_rd_tgt;
                estg_next  = MASK_W'(wm_rd_stg);
                last_next  = ((k_reg + CNT_W'(1)) == cur_cnt_reg);
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (last_next)
                        state_next = ST_IDLE;
                    else
                    begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_LRD;
                    end
                end
            end
            ST_DSNAP:
            begin
                cm_rd_en   = 1'b1;
                cm_rd_addr = i_reg;
                state_next = ST_DSNAPW;
            end
            ST_DSNAPW:
            begin
                snap_we = 1'b1;
                if (i_reg == LAST_SLOT)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_DENT;
                end
                else
                begin
                    i_next     = i_reg + SLOT_W'(1);
                    state_next = ST_DSNAP;
                end
            end
            ST_DENT:
            begin
                wm_rd_addr = ent_addr(i_reg, k_reg);
                if (k_reg < cnt_snap[i_reg])
                begin
                    wm_rd_en       = 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = i_reg;
                    k_next         = k_reg + CNT_W'(1);
                end
                else if (i_reg == LAST_SLOT)
                    state_next = ST_DWAIT;
                else
                begin
                    i_next = i_reg + SLOT_W'(1);
                    k_next = '0;
                end
            end
            ST_DWAIT:
            begin
                i_next     = '0;
                state_next = ST_DCLOSE;
            end
            ST_DCLOSE:
            begin
                cyc_ctl.close_step = 1'b1;
                if (i_reg == LAST_SLOT)
                    state_next = ST_DOUT;
                else
                    i_next = i_reg + SLOT_W'(1);
            end
            ST_DOUT:
            begin
                alloc_next = cur_next_reg - TL_W'(1);
                comm_next  = cur_comm_reg;
                upc_next   = cur_next_reg;
                dl_next    = cyc_deadlock;
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            async_reg     <= 1'b0;
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                async_reg <= cfg_wr_data;
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= opcode;
            slot_reg <= wrap_slot(map_queue(queue, async_reg));
            src_reg  <= wrap_slot(map_queue(source_queue, async_reg));
            tgt_reg  <= wait_target;
            stg_reg  <= STAGE_W'(stage_mask);
        end
        cur_next_reg  <= cur_next_next;
        cur_comm_reg  <= cur_comm_next;
        cur_cnt_reg   <= cur_cnt_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        pend_slot_reg <= pend_slot_next;
        if (snap_we)
        begin
            comm_snap[i_reg] <= cm_rd_comm;
            cnt_snap[i_reg]  <= cm_rd_cnt;
        end
        if (load_out)
        begin
            status_reg <= status_next;
            alloc_reg  <= alloc_next;
            comm_reg   <= comm_next;
            upc_reg    <= upc_next;
            ev_reg     <= ev_next;
            esrc_reg   <= esrc_next;
            etgt_reg   <= etgt_next;
            estg_reg   <= estg_next;
            dl_reg     <= dl_next;
            last_reg   <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign allocated_value = alloc_reg;
    assign committed_value = comm_reg;
    assign upcoming_value  = upc_reg;
    assign entry_valid     = ev_reg;
    assign entry_source    = esrc_reg;
    assign entry_target    = etgt_reg;
    assign entry_stage     = estg_reg;
    assign deadlock        = dl_reg;
    assign last            = last_reg;

    // A command transfer always leaves the block busy in the following cycle.
    `QTST_ASSERT_NXT(a_busy_after_xfer, in_xfer, in_stall)
    // Listed entries never carry a deadlock flag or an error status.
    `QTST_ASSERT_IMP(a_entry_clean, out_valid && entry_valid, status == STS_OK && !deadlock)
    // The deadlock flag only rides on a single, final result.
    `QTST_ASSERT_IMP(a_deadlock_last, out_valid && deadlock, last && !entry_valid)
    // The graph sweep never runs while counters are being written.
    `QTST_ASSERT_IMP(a_sweep_no_write, pend_reg, !cm_wr_en && !wm_wr_en)

endmodule

`default_nettype wire

### rtl/qtst_ctr_mem.sv
// ----------------------------------------------------------------------------
// Queue timeline sync tracker counter memory
// Per-slot next signal, committed value and wait count, with valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qtst_ctr_mem #(
    parameter int QUEUE_COUNT = 4,
    parameter int WAIT_DEPTH  = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              clr,
    input  wire logic                              rd_en,
    input  wire logic [$clog2(QUEUE_COUNT)-1:0]    rd_addr,
    output logic [qtst_pkg::TL_W-1:0]              rd_next,
    output logic [qtst_pkg::TL_W-1:0]              rd_comm,
    output logic [$clog2(WAIT_DEPTH+1)-1:0]        rd_cnt,
    input  wire logic                              wr_en,
    input  wire logic [$clog2(QUEUE_COUNT)-1:0]    wr_addr,
    input  wire logic [qtst_pkg::TL_W-1:0]         wr_next,
    input  wire logic [qtst_pkg::TL_W-1:0]         wr_comm,
    input  wire logic [$clog2(WAIT_DEPTH+1)-1:0]   wr_cnt
);
    import qtst_pkg::*;

    localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);

    logic [TL_W-1:0]  mem_next [QUEUE_COUNT];
    logic [TL_W-1:0]  mem_comm [QUEUE_COUNT];
    logic [CNT_W-1:0] mem_cnt  [QUEUE_COUNT];
    logic [QUEUE_COUNT-1:0] valid_reg;

    logic [TL_W-1:0]  rd_next_reg;
    logic [TL_W-1:0]  rd_comm_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic             rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_next[wr_addr] <= wr_next;
            mem_comm[wr_addr] <= wr_comm;
            mem_cnt[wr_addr]  <= wr_cnt;
        end
        if (rd_en)
        begin
            rd_next_reg <= mem_next[rd_addr];
            rd_comm_reg <= mem_comm[rd_addr];
            rd_cnt_reg  <= mem_cnt[rd_addr];
            rd_vld_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (clr)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[wr_addr] <= 1'b1;
    end

    // A slot never written since reset reads as its reset counters.
    assign rd_next = rd_vld_reg ? rd_next_reg : TL_W'(1);
    assign rd_comm = rd_vld_reg ? rd_comm_reg : '0;
    assign rd_cnt  = rd_vld_reg ? rd_cnt_reg  : '0;

endmodule

`default_nettype wire

### rtl/qtst_wait_mem.sv
// ----------------------------------------------------------------------------
// Queue timeline sync tracker wait memory
// Pending wait entries: source slot, target value and stage mask.
// ----------------------------------------------------------------------------
`default_nettype none

module qtst_wait_mem #(
    parameter int QUEUE_COUNT = 4,
    parameter int WAIT_DEPTH  = 8,
    parameter int STAGE_W     = 32
) (
    input  wire logic                                       clk,
    input  wire logic                                       rd_en,
    input  wire logic [$clog2(QUEUE_COUNT*WAIT_DEPTH)-1:0]  rd_addr,
    output logic [$clog2(QUEUE_COUNT)-1:0]                  rd_src,
    output logic [qtst_pkg::TL_W-1:0]                       rd_tgt,
    output logic [STAGE_W-1:0]                              rd_stg,
    input  wire logic                                       wr_en,
    input  wire logic [$clog2(QUEUE_COUNT*WAIT_DEPTH)-1:0]  wr_addr,
    input  wire logic [$clog2(QUEUE_COUNT)-1:0]             wr_src,
    input  wire logic [qtst_pkg::TL_W-1:0]                  wr_tgt,
    input  wire logic [STAGE_W-1:0]                         wr_stg
);
    import qtst_pkg::*;

    localparam int DEPTH  = QUEUE_COUNT * WAIT_DEPTH;
    localparam int SLOT_W = $clog2(QUEUE_COUNT);

    logic [SLOT_W-1:0]  mem_src [DEPTH];
    logic [TL_W-1:0]    mem_tgt [DEPTH];
    logic [STAGE_W-1:0] mem_stg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_src[wr_addr] <= wr_src;
            mem_tgt[wr_addr] <= wr_tgt;
            mem_stg[wr_addr] <= wr_stg;
        end
        if (rd_en)
        begin
            rd_src <= mem_src[rd_addr];
            rd_tgt <= mem_tgt[rd_addr];
            rd_stg <= mem_stg[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/qtst_cycle.sv
// ----------------------------------------------------------------------------
// Queue timeline sync tracker wait graph
// Reachability matrix of unmet waits, closed one pivot slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module qtst_cycle #(
    parameter int QUEUE_COUNT = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire qtst_pkg::cyc_ctl_t              ctl,
    input  wire logic [$clog2(QUEUE_COUNT)-1:0]  from_slot,
    input  wire logic [$clog2(QUEUE_COUNT)-1:0]  to_slot,
    input  wire logic [$clog2(QUEUE_COUNT)-1:0]  step_slot,
    output logic                                 deadlock
);
    import qtst_pkg::*;

    logic [QUEUE_COUNT-1:0] reach_reg [QUEUE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUE_COUNT; i++)
                reach_reg[i] <= '0;
        end
        else if (ctl.clear)
        begin
            for (int i = 0; i < QUEUE_COUNT; i++)
                reach_reg[i] <= '0;
        end
        else if (ctl.set_edge)
            reach_reg[from_slot][to_slot] <= 1'b1;
        else if (ctl.close_step)
        begin
            // One Warshall pivot: i reaches j through the step slot.
            for (int i = 0; i < QUEUE_COUNT; i++)
                if (reach_reg[i][step_slot])
                    reach_reg[i] <= reach_reg[i] | reach_reg[step_slot];
        end
    end

    always_comb
    begin
        deadlock = 1'b0;
        for (int i = 0; i < QUEUE_COUNT; i++)
            deadlock = deadlock | reach_reg[i][i];
    end

endmodule

`default_nettype wire
